// File: rtl/viterbi_deinterleave_decoder_unit_macros.svh
// assertion macros for the viterbi de-interleaving decoder
`ifndef VITERBI_DEINTERLEAVE_DECODER_UNIT_MACROS_SVH
`define VITERBI_DEINTERLEAVE_DECODER_UNIT_MACROS_SVH

// same-cycle implication under reset
`define VDD_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) else $error(msg);

// next-cycle implication under reset
`define VDD_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/vdd_pkg.sv
// shared types, constants and helpers for the viterbi de-interleaving decoder
`timescale 1ns / 1ps
package vdd_pkg;

  localparam int unsigned SurvivorBits = 32;
  localparam int unsigned NumStates    = 8;
  localparam int unsigned SymPerBlock  = 16;
  localparam int unsigned MaxOut       = 4;

  localparam int unsigned CntW  = $clog2(SurvivorBits + 1);
  localparam int unsigned SymW  = $clog2(SymPerBlock);
  localparam int unsigned IdxW  = $clog2(MaxOut);
  localparam int unsigned OcntW = $clog2(MaxOut + 1);

  typedef logic [7:0]              cost_t;
  typedef logic [SurvivorBits-1:0] path_t;
  typedef logic [CntW-1:0]         bitcnt_t;

  localparam cost_t StartCost = 8'd100;

  // expected symbol from each of the two sources of a destination state
  localparam logic [1:0] ExpectSym [NumStates][2] = '{
    '{2'd0, 2'd3}, '{2'd3, 2'd0}, '{2'd1, 2'd2}, '{2'd2, 2'd1},
    '{2'd3, 2'd0}, '{2'd0, 2'd3}, '{2'd2, 2'd1}, '{2'd1, 2'd2}
  };

  typedef enum logic [2:0] {
    StIdle,
    StStep,
    StFlush,
    StNorm,
    StDrain
  } vdd_state_e;

  // control from the sequencer to the result buffer
  typedef struct packed {
    logic       clr;
    logic       wr_en;
    logic [7:0] data;
    logic       pkt_end;
    logic       start;
  } buf_ctl_t;

  // status from the result buffer
  typedef struct packed {
    logic             busy;
    logic [OcntW-1:0] count;
  } buf_st_t;

  // hamming weight of a two-bit symbol
  function automatic logic [1:0] weight2(logic [1:0] v);
    return 2'(v[0]) + 2'(v[1]);
  endfunction

endpackage

// File: rtl/vdd_if.sv
// valid/ready channel interfaces for input items and decoded bytes
`timescale 1ns / 1ps
interface vdd_in_if;
  logic        valid;
  logic        ready;
  logic        start_packet;
  logic [31:0] received_word;
  logic [7:0]  bytes_remaining;

  modport source (output valid, start_packet, received_word, bytes_remaining, input ready);
  modport sink   (input valid, start_packet, received_word, bytes_remaining, output ready);
endinterface

interface vdd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] decoded_byte;
  logic       last_of_item;
  logic       packet_end;

  modport source (output valid, decoded_byte, last_of_item, packet_end, input ready);
  modport sink   (input valid, decoded_byte, last_of_item, packet_end, output ready);
endinterface

// File: rtl/viterbi_deinterleave_decoder_unit.sv
// viterbi de-interleaving decoder top level: sequencer, trellis state and result buffer
//
// Input channel in_i carries one item per handshake: a start mark (start_packet = 1),
// which clears the trellis state when it is accepted and yields no bytes, or a 32-bit block
// of interleaved received data with the count of bytes still expected.
// A data block is taken apart into up to 16 two-bit symbols, one per cycle, and a single
// eight-wide add-compare-select unit advances the trellis once per cycle.
// Decoded bytes (up to four per block) are collected in a small buffer and then
// sent on out_o one per cycle while out_o is ready, the last one flagged with last_of_item.
// Each block is accepted, stepped symbol by symbol, then either normalised or flushed
// byte by byte, and its bytes are delivered before the block returns to idle.
// in_i.ready is high only while the block is idle; one item is in work at a time.
// When out_o stalls, the current byte holds and the block waits before taking
// the next item.
// Reset (rst_ni low, asynchronous) puts state 0 at cost 0, all other states at 100,
// clears the survivor paths and the path bit count, and drops any pending bytes.
`timescale 1ns / 1ps
`include "viterbi_deinterleave_decoder_unit_macros.svh"
module viterbi_deinterleave_decoder_unit (
  input  logic     clk_i,
  input  logic     rst_ni,
  vdd_in_if.sink   in_i,
  vdd_out_if.source out_o
);
  import vdd_pkg::*;

  vdd_state_e state_q, state_d;

  cost_t   cost_q  [NumStates];
  path_t   path_q  [NumStates];
  cost_t   ncost   [NumStates];
  path_t   npath   [NumStates];
  bitcnt_t cnt_q;
  logic [31:0]     word_q;
  logic [7:0]      rem_q;
  logic            wrap_q;
  logic [SymW-1:0] sym_q;

  logic        accept;
  logic [4:0]  sym_pos;
  logic [1:0]  sym;
  bitcnt_t     cnt_inc, cnt_after, flush_sh;
  logic        emit_full;
  logic [7:0]  rem_after;
  logic        wrap_after;
  logic        flush_hit;
  logic        flush_more;
  logic        last_sym;
  cost_t       min_cost;

  buf_ctl_t buf_ctl;
  buf_st_t  buf_st;

  // symbol extraction: lane 3-s[1:0], group s[3:2]
  assign sym_pos = {~sym_q[1:0], sym_q[3:2], 1'b0};
  assign sym     = word_q[sym_pos +: 2];

  vdd_acs_unit u_acs (
    .sym_i   (sym),
    .cost_i  (cost_q),
    .path_i  (path_q),
    .ncost_o (ncost),
    .npath_o (npath)
  );

  // path bit bookkeeping for the current step
  assign cnt_inc    = cnt_q + CntW'(1);
  assign emit_full  = (cnt_inc == CntW'(SurvivorBits));
  assign cnt_after  = emit_full ? (cnt_inc - CntW'(8)) : cnt_inc;
  assign rem_after  = emit_full ? (rem_q - 8'd1) : rem_q;
  assign wrap_after = wrap_q | (emit_full && (rem_q == 8'd0));
  assign flush_hit  = !wrap_after && (rem_after <= 8'd3)
                      && (cnt_after == CntW'({rem_after[1:0], 3'b011}));
  assign last_sym   = (sym_q == SymW'(SymPerBlock - 1));
  assign flush_more = (cnt_q >= CntW'(8));
  assign flush_sh   = cnt_q - CntW'(8);
  assign accept     = in_i.valid && in_i.ready;

  // minimum cost over all states for normalisation
  always_comb begin
    min_cost = cost_q[0];
    for (int k = 1; k < NumStates; k++) begin
      if (cost_q[k] < min_cost) min_cost = cost_q[k];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept && !in_i.start_packet) state_d = StStep;
      end
      StStep: begin
        if (flush_hit) state_d = StFlush;
        else if (last_sym) state_d = StNorm;
      end
      StFlush: begin
        if (!flush_more) state_d = StDrain;
      end
      StNorm:  state_d = StDrain;
      StDrain: begin
        if (!buf_st.busy) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_i.ready      = 1'b0;
    buf_ctl         = '0;
    unique case (state_q)
      StIdle: begin
        in_i.ready  = 1'b1;
        buf_ctl.clr = in_i.valid && !in_i.start_packet;
      end
      StStep: begin
        buf_ctl.wr_en   = emit_full;
        buf_ctl.data    = npath[0][SurvivorBits-1 -: 8];
        buf_ctl.pkt_end = 1'b0;
      end
      StFlush: begin
        buf_ctl.wr_en   = flush_more;
        buf_ctl.data    = 8'(path_q[0] >> flush_sh);
        buf_ctl.pkt_end = 1'b1;
        buf_ctl.start   = !flush_more;
      end
      StNorm: begin
        buf_ctl.start = 1'b1;
      end
      StDrain: begin
        buf_ctl = '0;
      end
      default: buf_ctl = '0;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end

  // trellis state: costs, survivor paths and bit count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumStates; k++) begin
        cost_q[k] <= (k == 0) ? '0 : StartCost;
        path_q[k] <= '0;
      end
      cnt_q <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (accept && in_i.start_packet) begin
            for (int k = 0; k < NumStates; k++) begin
              cost_q[k] <= (k == 0) ? '0 : StartCost;
              path_q[k] <= '0;
            end
            cnt_q <= '0;
          end
        end
        StStep: begin
          cost_q <= ncost;
          path_q <= npath;
          cnt_q  <= cnt_after;
        end
        StFlush: begin
          if (flush_more) cnt_q <= flush_sh;
        end
        StNorm: begin
          for (int k = 0; k < NumStates; k++) cost_q[k] <= cost_q[k] - min_cost;
        end
        StDrain: cnt_q <= cnt_q;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // block context: remaining byte count, wrap flag and symbol index (the word register follows)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_q  <= '0;
      rem_q  <= '0;
      wrap_q <= 1'b0;
    end else if (state_q == StIdle) begin
      if (accept && !in_i.start_packet) begin
        sym_q  <= '0;
        rem_q  <= in_i.bytes_remaining;
        wrap_q <= 1'b0;
      end
    end else if (state_q == StStep) begin
      sym_q  <= sym_q + SymW'(1);
      rem_q  <= rem_after;
      wrap_q <= wrap_after;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !in_i.start_packet) word_q <= in_i.received_word;
  end

  vdd_out_buf u_out_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (buf_ctl),
    .st_o   (buf_st),
    .out_o  (out_o)
  );

  // checks on sequencing and bookkeeping
  `VDD_ASSERT_IMP(a_no_accept_while_drain, clk_i, rst_ni, out_o.valid, !in_i.ready, "input accepted while bytes pending")
  `VDD_ASSERT_IMP(a_bitcnt_range, clk_i, rst_ni, 1'b1, cnt_q < CntW'(SurvivorBits), "path bit count out of range")
  `VDD_ASSERT_IMP(a_buf_count, clk_i, rst_ni, 1'b1, buf_st.count <= OcntW'(MaxOut), "result buffer overfilled")
  `VDD_ASSERT_NXT(a_step_not_idle, clk_i, rst_ni, state_q == StStep, state_q != StIdle, "symbol step returned straight to idle")

endmodule

// File: rtl/vdd_acs_unit.sv
// add-compare-select over all eight trellis states for one symbol
`timescale 1ns / 1ps
module vdd_acs_unit (
  input  logic [1:0]     sym_i,
  input  vdd_pkg::cost_t cost_i  [vdd_pkg::NumStates],
  input  vdd_pkg::path_t path_i  [vdd_pkg::NumStates],
  output vdd_pkg::cost_t ncost_o [vdd_pkg::NumStates],
  output vdd_pkg::path_t npath_o [vdd_pkg::NumStates]
);
  import vdd_pkg::*;

  cost_t c0 [NumStates];
  cost_t c1 [NumStates];
  logic  sel_b [NumStates];

  // branch costs, compare, survivor extension; ties go to the first source
  always_comb begin
    for (int d = 0; d < NumStates; d++) begin
      c0[d] = cost_i[d / 2] + cost_t'(weight2(sym_i ^ ExpectSym[d][0]));
      c1[d] = cost_i[d / 2 + NumStates / 2] + cost_t'(weight2(sym_i ^ ExpectSym[d][1]));
      sel_b[d] = (c0[d] > c1[d]);
      ncost_o[d] = sel_b[d] ? c1[d] : c0[d];
      npath_o[d] = sel_b[d]
        ? {path_i[d / 2 + NumStates / 2][SurvivorBits-2:0], 1'(d)}
        : {path_i[d / 2][SurvivorBits-2:0], 1'(d)};
    end
  end

endmodule

// File: rtl/vdd_out_buf.sv
// per-block result buffer that collects up to four bytes and drains them
`timescale 1ns / 1ps
module vdd_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vdd_pkg::buf_ctl_t ctl_i,
  output vdd_pkg::buf_st_t  st_o,
  vdd_out_if.source         out_o
);
  import vdd_pkg::*;

  logic [7:0]       data_q [MaxOut];
  logic             end_q  [MaxOut];
  logic [OcntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0]  rd_q, rd_d;
  logic             busy_q, busy_d;
  logic             wr_ok;
  logic             at_last;

  assign wr_ok   = ctl_i.wr_en && (cnt_q < OcntW'(MaxOut));
  assign at_last = ({1'b0, rd_q} == (cnt_q - OcntW'(1)));

  // fill count and drain pointer
  always_comb begin
    cnt_d  = cnt_q;
    rd_d   = rd_q;
    busy_d = busy_q;
    if (ctl_i.clr) begin
      cnt_d = '0;
    end else if (wr_ok) begin
      cnt_d = cnt_q + OcntW'(1);
    end
    if (ctl_i.start) begin
      busy_d = (cnt_q != '0);
      rd_d   = '0;
    end else if (busy_q && out_o.ready) begin
      if (at_last) begin
        busy_d = 1'b0;
      end else begin
        rd_d = rd_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      rd_q   <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      rd_q   <= rd_d;
      busy_q <= busy_d;
    end
  end

  // byte storage, extra bytes beyond the fourth are dropped
  always_ff @(posedge clk_i) begin
    if (wr_ok && !ctl_i.clr) begin
      data_q[cnt_q[IdxW-1:0]] <= ctl_i.data;
      end_q[cnt_q[IdxW-1:0]]  <= ctl_i.pkt_end;
    end
  end

  assign out_o.valid        = busy_q;
  assign out_o.decoded_byte = data_q[rd_q];
  assign out_o.packet_end   = end_q[rd_q];
  assign out_o.last_of_item = at_last;

  assign st_o.busy  = busy_q;
  assign st_o.count = cnt_q;

endmodule

// File: test/viterbi_deinterleave_decoder_unit_tb.sv
// self-checking testbench for the viterbi de-interleaving decoder unit
`timescale 1ns / 1ps

// one decoded byte as it should appear on the output channel
typedef struct packed {
  logic [7:0] value;
  logic       last_of_item;
  logic       packet_end;
} decoded_byte_t;

// trellis predictor and store of decoded bytes still to arrive
class viterbi_scoreboard;
  // symbol expected from the lower source of each state, two bits per state;
  // the upper source expects the complement
  localparam logic [15:0] LowerSym = 16'h639C;
  localparam int          MaxBytes = 4;
  localparam int          MaxShown = 10;

  vdd_pkg::cost_t  metric [8];
  vdd_pkg::path_t  survivor [8];
  int unsigned     held_bits;
  decoded_byte_t   expected_bytes [$];

  int errors;
  int bytes_checked;
  int packet_starts;
  int flushes;
  int overflow_blocks;

  function new();
    clear_trellis();
  endfunction

  // state after reset or a start item
  function void clear_trellis();
    for (int s = 0; s < 8; s++) begin
      metric[s]   = (s == 0) ? 8'd0 : 8'd100;
      survivor[s] = '0;
    end
    held_bits = 0;
  endfunction

  function int unsigned waiting();
    return expected_bytes.size();
  endfunction

  // queue a byte unless the block already has its four
  function void stash(logic [7:0] b, bit at_end, inout int made);
    decoded_byte_t e;
    if (made < MaxBytes) begin
      e.value        = b;
      e.last_of_item = 1'b0;
      e.packet_end   = at_end;
      expected_bytes.push_back(e);
    end
    made++;
  endfunction

  // run one accepted item through the trellis and queue what it decodes
  function void decode_block(input logic st, input logic [31:0] word,
                             input logic [7:0] rem_in, output bit flushed,
                             output int rem_out);
    vdd_pkg::cost_t nmetric [8];
    vdd_pkg::path_t nsurv [8];
    vdd_pkg::cost_t low;
    vdd_pkg::cost_t c0;
    vdd_pkg::cost_t c1;
    logic [1:0]     sym;
    logic [1:0]     first;
    logic [15:0]    rem;
    decoded_byte_t  e;
    int             lane;
    int             grp;
    int             src;
    int             made;

    flushed = 1'b0;
    rem_out = rem_in;
    if (st) begin
      clear_trellis();
      packet_starts++;
      return;
    end
    rem  = {8'd0, rem_in};
    made = 0;
    low  = 8'hFF;
    for (int s = 0; s < 16 && !flushed; s++) begin
      // de-interleave: lanes from the top byte down, groups from the low bits up
      lane = 3 - (s % 4);
      grp  = s / 4;
      sym  = word[8*lane + 2*grp +: 2];
      low  = 8'hFF;
      // add-compare-select, ties go to the lower source
      for (int d = 0; d < 8; d++) begin
        first = LowerSym[2*d +: 2];
        c0 = metric[d/2] + 8'($countones(sym ^ first));
        c1 = metric[d/2 + 4] + 8'($countones(sym ^ ~first));
        src = (c0 <= c1) ? d/2 : d/2 + 4;
        nmetric[d] = (c0 <= c1) ? c0 : c1;
        if (nmetric[d] < low) low = nmetric[d];
        nsurv[d] = {survivor[src][30:0], 1'(d & 1)};
      end
      metric   = nmetric;
      survivor = nsurv;
      held_bits++;
      // full survivor window: release its oldest byte
      if (held_bits == 32) begin
        stash(survivor[0][31:24], 1'b0, made);
        held_bits -= 8;
        rem = rem - 16'd1;
      end
      // packet end reached: empty the path
      if (rem <= 3 && held_bits == 8*rem + 3) begin
        while (held_bits >= 8) begin
          stash(survivor[0][held_bits-1 -: 8], 1'b1, made);
          held_bits -= 8;
        end
        flushed = 1'b1;
        flushes++;
      end
    end
    // normalise by the smallest cost of the last symbol
    if (!flushed) begin
      for (int k = 0; k < 8; k++) metric[k] = metric[k] - low;
    end
    if (made > MaxBytes) overflow_blocks++;
    if (made > 0) begin
      e = expected_bytes.pop_back();
      e.last_of_item = 1'b1;
      expected_bytes.push_back(e);
    end
    rem_out = rem;
  endfunction

  function void report(string what);
    errors++;
    if (errors <= MaxShown) $display("[%0t] %s", $realtime, what);
  endfunction

  // compare one delivered byte with the oldest one queued
  function void check_byte(logic [7:0] b, logic last, logic pe);
    decoded_byte_t e;
    if (expected_bytes.size() == 0) begin
      report($sformatf("unexpected byte %02h last %0b end %0b", b, last, pe));
      return;
    end
    e = expected_bytes.pop_front();
    bytes_checked++;
    if (b !== e.value || last !== e.last_of_item || pe !== e.packet_end)
      report($sformatf("byte mismatch: expected %02h last %0b end %0b, got %02h last %0b end %0b",
                       e.value, e.last_of_item, e.packet_end, b, last, pe));
  endfunction
endclass

module viterbi_deinterleave_decoder_unit_tb;

  logic clk_i;
  logic rst_ni;

  vdd_in_if  in_if ();
  vdd_out_if out_if ();

  viterbi_deinterleave_decoder_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  viterbi_scoreboard board;
  int send_idle;
  int recv_idle;
  int hold_cycles;
  int longest_hold;
  int items_sent;

  // clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // run limit
  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

  // output back-pressure, with the occasional long hold-off
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_if.ready = 1'b0;
        hold_cycles--;
      end else begin
        out_if.ready = (recv_idle == 0) || ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      board.check_byte(out_if.decoded_byte, out_if.last_of_item, out_if.packet_end);
  end

  // mostly random words, now and then an extreme
  function automatic logic [31:0] pick_word();
    case ($urandom_range(15))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // offer one item after a random gap and hold it until it is taken
  task automatic offer(input logic st, input logic [31:0] w, input logic [7:0] r,
                       output bit flushed, output int left);
    while (send_idle != 0 && $urandom_range(99) < send_idle) @(negedge clk_i);
    in_if.valid           = 1'b1;
    in_if.start_packet    = st;
    in_if.received_word   = w;
    in_if.bytes_remaining = r;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    board.decode_block(st, w, r, flushed, left);
    items_sent++;
    @(negedge clk_i);
    in_if.valid = 1'b0;
  endtask

  // start mark then blocks with a tracked byte count, optionally cut short
  task automatic run_packet(input int len, input int cut);
    bit done;
    int left;
    int blocks;
    offer(1'b1, $urandom, 8'($urandom), done, left);
    left   = len;
    done   = 1'b0;
    blocks = 0;
    while (!done && (cut == 0 || blocks < cut)) begin
      offer(1'b0, pick_word(), 8'(left), done, left);
      blocks++;
    end
  endtask

  // mostly whole packets, the rest stray blocks, stray starts and broken packets
  task automatic random_traffic(input int target);
    bit done;
    int left;
    int base;
    int pick;
    int len;
    base = items_sent;
    while (items_sent - base < target) begin
      pick = $urandom_range(99);
      len  = ($urandom_range(9) == 0) ? $urandom_range(12, 40) : $urandom_range(0, 8);
      if (pick < 70) run_packet(len, 0);
      else if (pick < 80) run_packet(len, $urandom_range(1, 3));
      else if (pick < 92) offer(1'b0, pick_word(), 8'($urandom), done, left);
      else offer(1'b1, $urandom, 8'($urandom), done, left);
    end
  endtask

  task automatic wait_for_bytes();
    while (board.waiting() != 0) @(negedge clk_i);
  endtask

  initial begin
    bit done;
    int left;

    board                 = new();
    rst_ni                = 1'b0;
    in_if.valid           = 1'b0;
    in_if.start_packet    = 1'b0;
    in_if.received_word   = '0;
    in_if.bytes_remaining = '0;
    send_idle             = 35;
    recv_idle             = 86;
    hold_cycles           = 0;
    longest_hold          = 0;
    items_sent            = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // start with junk in the ignored fields
    offer(1'b1, 32'hFFFF_FFFF, 8'hFF, done, left);
    // empty packet: flush with nothing left to emit
    offer(1'b0, 32'h0000_0000, 8'd0, done, left);
    // carry on after the flush without a start, ending three bits past a byte
    offer(1'b0, 32'hFFFF_FFFF, 8'hFF, done, left);
    offer(1'b0, 32'hAAAA_AAAA, 8'hFF, done, left);
    // two full-window bytes and a three-byte flush in one block: fifth dropped
    offer(1'b0, 32'h5555_5555, 8'd5, done, left);
    offer(1'b0, $urandom, 8'hFF, done, left);
    // one-byte packet of zeros
    offer(1'b1, 32'h0, 8'd0, done, left);
    offer(1'b0, 32'h0000_0000, 8'd1, done, left);
    // three-byte packet of ones
    offer(1'b1, 32'h0, 8'd0, done, left);
    offer(1'b0, 32'hFFFF_FFFF, 8'd3, done, left);
    offer(1'b0, 32'hFFFF_FFFF, 8'd3, done, left);
    // a packet that spans a normal byte and then the flush, and a shorter one that only flushes
    run_packet(4, 0);
    run_packet(2, 0);
    wait_for_bytes();

    // sender busy, receiver slow
    random_traffic(40);
    wait_for_bytes();

    // sender slow, receiver busy
    send_idle = 86;
    recv_idle = 35;
    random_traffic(40);
    wait_for_bytes();

    // no idling; a long output hold-off while items keep coming
    send_idle    = 0;
    recv_idle    = 0;
    hold_cycles  = 400;
    longest_hold = 400;
    run_packet(30, 0);
    random_traffic(15);
    // pause the input until every byte is out
    wait_for_bytes();
    random_traffic(25);

    wait_for_bytes();
    repeat (40) @(negedge clk_i);

    $display("run covered %0d items: %0d packet starts, %0d flushes, %0d over-full blocks",
             items_sent, board.packet_starts, board.flushes, board.overflow_blocks);
    $display("%0d decoded bytes checked, output held off for up to %0d cycles, %0d mismatches",
             board.bytes_checked, longest_hold, board.errors);
    if (board.errors == 0 && board.waiting() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
